// ===== hdl/pcc_pkg.sv =====
`timescale 1ns / 1ps

package pcc_pkg;

    localparam int SampleW = 16;
    localparam int GainW   = 16;
    localparam int LimW    = 15;
    localparam int CfgIdxW = 3;
    localparam int CfgW    = 16;

    // register indexes on the configuration port
    localparam logic [CfgIdxW-1:0] REG_MODE   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_ERRLIM = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_SEPTH  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_INTLIM = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_OUTLIM = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_KP     = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_KI     = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_KD     = 3'd7;

    // mode flag bit positions
    localparam int MODE_ERR_CLAMP = 0;
    localparam int MODE_INT_CLAMP = 1;
    localparam int MODE_SEPARATE  = 2;

    localparam logic [2:0]      MODE_RESET   = 3'd2;
    localparam logic [15:0]     ERRLIM_RESET = 16'd500;
    localparam logic [LimW-1:0] INTLIM_RESET = 15'd1000;
    localparam logic [LimW-1:0] OUTLIM_RESET = 15'd5000;

    typedef struct packed {
        logic signed [SampleW-1:0] target;
        logic signed [SampleW-1:0] measured;
    } t_pid_in;

    typedef struct packed {
        logic signed [SampleW-1:0] drive;
        logic                      drive_clamped;
    } t_pid_out;

endpackage

// ===== hdl/pid_controller_clamped_core.sv =====
`timescale 1ns / 1ps

// channel  | valid        | stall        | payload
// ---------+--------------+--------------+-------------------------------
// input    | i_in_valid   | o_in_stall   | i_in  (target, measured)
// output   | o_out_valid  | i_out_stall  | o_out (drive, drive_clamped)
// config   | i_cfg_we     | -            | i_cfg_idx, i_cfg_data
//
// Five register stages (input, error, products, integrator, output): one item
// per cycle sustained while the output is not stalled.
// The integrator add/saturate/clamp closes its loop in a single stage, which
// is what allows an item every cycle.
// Reset (synchronous, active low) empties the pipe, clears the integrator and
// previous error and loads the register defaults.
// Each stage advances whenever the one after it is empty or moving, so items
// keep being accepted into empty stages while a result waits to be taken.

module pid_controller_clamped_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  pcc_pkg::t_pid_in                 i_in,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output pcc_pkg::t_pid_out                o_out,
    input  logic                             i_cfg_we,
    input  logic [pcc_pkg::CfgIdxW-1:0]      i_cfg_idx,
    input  logic [pcc_pkg::CfgW-1:0]         i_cfg_data
);
    import pcc_pkg::*;

    localparam logic signed [40:0] IntMax = {2'b00, {39{1'b1}}};
    localparam logic signed [40:0] IntMin = {2'b11, {39{1'b0}}};

    // configuration
    logic [2:0]       r_mode;
    logic [15:0]      r_errlim;
    logic [15:0]      r_septh;
    logic [LimW-1:0]  r_intlim;
    logic [LimW-1:0]  r_outlim;
    logic [GainW-1:0] r_kp;
    logic [GainW-1:0] r_ki;
    logic [GainW-1:0] r_kd;

    // pipeline
    logic                r_v0, r_v1, r_v2, r_v3, r_vo;
    t_pid_in             r_in0;
    logic signed [16:0]  r_err1;
    logic signed [17:0]  r_diff1;
    logic signed [16:0]  r_prev_err;
    logic signed [33:0]  r_pprod2;
    logic signed [33:0]  r_iprod2;
    logic signed [34:0]  r_dprod2;
    logic                r_integ_en2;
    logic signed [39:0]  r_integ;
    logic signed [35:0]  r_pd3;
    t_pid_out            r_out;

    logic rdy_o, rdy3, rdy2, rdy1, rdy0;

    assign rdy_o = !r_vo || !i_out_stall;
    assign rdy3  = !r_v3 || rdy_o;
    assign rdy2  = !r_v2 || rdy3;
    assign rdy1  = !r_v1 || rdy2;
    assign rdy0  = !r_v0 || rdy1;

    assign o_in_stall  = !rdy0;
    assign o_out_valid = r_vo;
    assign o_out       = r_out;

    // stage 1: error, clamp, difference to the last error
    logic signed [16:0] n_err_raw, n_err, lim_err;
    logic signed [17:0] n_diff;

    always_comb begin
        lim_err   = $signed({1'b0, r_errlim});
        n_err_raw = {r_in0.target[15], r_in0.target} - {r_in0.measured[15], r_in0.measured};
        n_err     = n_err_raw;
        if (r_mode[MODE_ERR_CLAMP]) begin
            if (n_err_raw > lim_err) begin
                n_err = lim_err;
            end else if (n_err_raw < -lim_err) begin
                n_err = -lim_err;
            end
        end
        n_diff = {n_err[16], n_err} - {r_prev_err[16], r_prev_err};
    end

    // stage 2: gain products and separation decision
    logic [16:0]        abs_err;
    logic               n_integ_en;
    logic signed [33:0] n_pprod, n_iprod;
    logic signed [34:0] n_dprod;

    always_comb begin
        abs_err    = r_err1[16] ? 17'(-r_err1) : 17'(r_err1);
        n_integ_en = !r_mode[MODE_SEPARATE] || (abs_err <= {1'b0, r_septh});
        n_pprod    = $signed({1'b0, r_kp}) * r_err1;
        n_iprod    = $signed({1'b0, r_ki}) * r_err1;
        n_dprod    = $signed({1'b0, r_kd}) * r_diff1;
    end

    // stage 3: integrator update (saturate to 40 bits, then optional clamp)
    logic signed [40:0] acc;
    logic signed [39:0] n_sat, n_integ, ilim;
    logic signed [35:0] n_pd;

    always_comb begin
        ilim  = $signed({17'd0, r_intlim, 8'd0});
        acc   = {r_integ[39], r_integ} + 41'(r_iprod2);
        if (acc > IntMax) begin
            n_sat = IntMax[39:0];
        end else if (acc < IntMin) begin
            n_sat = IntMin[39:0];
        end else begin
            n_sat = acc[39:0];
        end
        if (!r_integ_en2) begin
            n_sat = r_integ;
        end
        n_integ = n_sat;
        if (r_mode[MODE_INT_CLAMP]) begin
            if (n_sat > ilim) begin
                n_integ = ilim;
            end else if (n_sat < -ilim) begin
                n_integ = -ilim;
            end
        end
        n_pd = 36'(r_pprod2) + 36'(r_dprod2);
    end

    // output stage: total, floor, output clamp
    logic signed [41:0] total;
    logic signed [33:0] floored, olim;
    t_pid_out           n_out;

    always_comb begin
        total   = 42'(r_integ) + 42'(r_pd3);
        floored = total[41:8];
        olim    = $signed({19'd0, r_outlim});
        n_out.drive_clamped = 1'b0;
        n_out.drive         = floored[15:0];
        if (floored > olim) begin
            n_out.drive         = olim[15:0];
            n_out.drive_clamped = 1'b1;
        end else if (floored < -olim) begin
            n_out.drive         = 16'(-olim);
            n_out.drive_clamped = 1'b1;
        end
    end

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0       <= 1'b0;
            r_v1       <= 1'b0;
            r_v2       <= 1'b0;
            r_v3       <= 1'b0;
            r_vo       <= 1'b0;
            r_prev_err <= '0;
            r_integ    <= '0;
            r_mode     <= MODE_RESET;
            r_errlim   <= ERRLIM_RESET;
            r_septh    <= '0;
            r_intlim   <= INTLIM_RESET;
            r_outlim   <= OUTLIM_RESET;
            r_kp       <= '0;
            r_ki       <= '0;
            r_kd       <= '0;
        end else begin
            if (rdy0) r_v0 <= i_in_valid;
            if (rdy1) r_v1 <= r_v0;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy_o) r_vo <= r_v3;
            if (rdy1 && r_v0) r_prev_err <= n_err;
            if (rdy3 && r_v2) r_integ <= n_integ;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MODE:   r_mode   <= i_cfg_data[2:0];
                    REG_ERRLIM: r_errlim <= i_cfg_data;
                    REG_SEPTH:  r_septh  <= i_cfg_data;
                    REG_INTLIM: r_intlim <= i_cfg_data[LimW-1:0];
                    REG_OUTLIM: r_outlim <= i_cfg_data[LimW-1:0];
                    REG_KP:     r_kp     <= i_cfg_data;
                    REG_KI:     r_ki     <= i_cfg_data;
                    REG_KD:     r_kd     <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (rdy0 && i_in_valid) r_in0 <= i_in;
        if (rdy1 && r_v0) begin
            r_err1  <= n_err;
            r_diff1 <= n_diff;
        end
        if (rdy2 && r_v1) begin
            r_pprod2    <= n_pprod;
            r_iprod2    <= n_iprod;
            r_dprod2    <= n_dprod;
            r_integ_en2 <= n_integ_en;
        end
        if (rdy3 && r_v2) r_pd3 <= n_pd;
        if (rdy_o && r_v3) r_out <= n_out;
    end

endmodule

// ===== hdl/pcc_checker.sv =====
`timescale 1ns / 1ps

module pcc_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        o_in_stall,
    input  logic                        o_out_valid,
    input  logic                        i_out_stall,
    input  pcc_pkg::t_pid_out           o_out
);
    import pcc_pkg::*;

    // a waiting result stays up until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out))
        else $error("stalled result changed");

    // with the output slot empty the whole pipe drains, so input is never held
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

    // the limit is at most 32767, so the most negative code never appears
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.drive != 16'sh8000))
        else $error("drive outside limit range");

    // nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result after reset");

endmodule

bind pid_controller_clamped_core pcc_checker u_pcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

// ===== tb/sv/pid_drive_checker.sv =====
`timescale 1ns / 1ps

module pid_drive_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  pcc_pkg::t_pid_in            i_in,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  pcc_pkg::t_pid_out           i_out,
    input  logic                        i_cfg_we,
    input  logic [pcc_pkg::CfgIdxW-1:0] i_cfg_idx,
    input  logic [pcc_pkg::CfgW-1:0]    i_cfg_data,
    output int                          o_errors,
    output int                          o_pending
);

    localparam longint IntegMax = 64'sd549755813887;
    localparam longint IntegMin = -IntegMax - 1;

    // shadow copy of the register file
    logic [2:0]                 cfg_mode;
    logic [15:0]                cfg_errlim;
    logic [15:0]                cfg_septh;
    logic [pcc_pkg::LimW-1:0]   cfg_intlim;
    logic [pcc_pkg::LimW-1:0]   cfg_outlim;
    logic [pcc_pkg::GainW-1:0]  cfg_kp;
    logic [pcc_pkg::GainW-1:0]  cfg_ki;
    logic [pcc_pkg::GainW-1:0]  cfg_kd;

    // controller state: last clamped error and Q32.8 integrator
    logic signed [17:0]         prev_err;
    logic signed [39:0]         integ;

    pcc_pkg::t_pid_out          drive_q[$];
    int                         mismatches;

    initial begin
        mismatches = 0;
    end

    function automatic longint clamp_mag(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic pcc_pkg::t_pid_out step_controller(input pcc_pkg::t_pid_in item);
        longint            err;
        longint            abs_err;
        longint            acc;
        longint            sum;
        longint            drv;
        longint            lim;
        pcc_pkg::t_pid_out res;
        err = longint'(item.target) - longint'(item.measured);
        if (cfg_mode[pcc_pkg::MODE_ERR_CLAMP]) begin
            err = clamp_mag(err, longint'(cfg_errlim));
        end
        abs_err = (err < 0) ? -err : err;
        acc = longint'(integ);
        if (!cfg_mode[pcc_pkg::MODE_SEPARATE] || abs_err <= longint'(cfg_septh)) begin
            acc = acc + longint'(cfg_ki) * err;
            // saturate at the 40-bit range
            if (acc > IntegMax) acc = IntegMax;
            if (acc < IntegMin) acc = IntegMin;
        end
        if (cfg_mode[pcc_pkg::MODE_INT_CLAMP]) begin
            acc = clamp_mag(acc, longint'(cfg_intlim) <<< 8);
        end
        integ = 40'(acc);
        sum = longint'(cfg_kp) * err + acc
            + longint'(cfg_kd) * (err - longint'(prev_err));
        drv = sum >>> 8;    // floor toward minus infinity
        lim = longint'(cfg_outlim);
        res.drive_clamped = 1'b0;
        if (drv > lim) begin
            drv = lim;
            res.drive_clamped = 1'b1;
        end
        if (drv < -lim) begin
            drv = -lim;
            res.drive_clamped = 1'b1;
        end
        res.drive = 16'(drv);
        prev_err = 18'(err);
        return res;
    endfunction

    always @(posedge i_clk) begin : check_proc
        pcc_pkg::t_pid_out want;
        if (!i_rst_n) begin
            cfg_mode   = pcc_pkg::MODE_RESET;
            cfg_errlim = pcc_pkg::ERRLIM_RESET;
            cfg_septh  = '0;
            cfg_intlim = pcc_pkg::INTLIM_RESET;
            cfg_outlim = pcc_pkg::OUTLIM_RESET;
            cfg_kp     = '0;
            cfg_ki     = '0;
            cfg_kd     = '0;
            prev_err   = '0;
            integ      = '0;
            drive_q.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                drive_q.push_back(step_controller(i_in));
            end
            if (i_out_valid && !i_out_stall) begin
                if (drive_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: drive %0d clamped %0b with no item pending",
                                 $realtime, i_out.drive, i_out.drive_clamped);
                    end
                end else begin
                    want = drive_q.pop_front();
                    if (i_out.drive !== want.drive
                            || i_out.drive_clamped !== want.drive_clamped) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"%0t: expected drive %0d clamped %0b, ",
                                      "got drive %0d clamped %0b"},
                                     $realtime, want.drive, want.drive_clamped,
                                     i_out.drive, i_out.drive_clamped);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    pcc_pkg::REG_MODE:   cfg_mode   = i_cfg_data[2:0];
                    pcc_pkg::REG_ERRLIM: cfg_errlim = i_cfg_data;
                    pcc_pkg::REG_SEPTH:  cfg_septh  = i_cfg_data;
                    pcc_pkg::REG_INTLIM: cfg_intlim = i_cfg_data[pcc_pkg::LimW-1:0];
                    pcc_pkg::REG_OUTLIM: cfg_outlim = i_cfg_data[pcc_pkg::LimW-1:0];
                    pcc_pkg::REG_KP:     cfg_kp     = i_cfg_data;
                    pcc_pkg::REG_KI:     cfg_ki     = i_cfg_data;
                    pcc_pkg::REG_KD:     cfg_kd     = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending <= drive_q.size();
        o_errors  <= mismatches;
    end

endmodule

// ===== tb/sv/tb_pid_controller_clamped_core.sv =====
`timescale 1ns / 1ps

module tb_pid_controller_clamped_core;

    localparam int ClkPeriod   = 4;
    localparam int ResetCycles = 10;
    localparam int QuietLimit  = 4000;
    localparam int HoldCycles  = 300;
    localparam int DrainWait   = 8;
    localparam int RandPhases  = 8;
    localparam int PhaseItems  = 190;
    localparam int HoldPhase   = 3;

    logic                        i_clk      = 1'b0;
    logic                        i_rst_n    = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    pcc_pkg::t_pid_in            i_in       = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    pcc_pkg::t_pid_out           o_out;
    logic                        i_cfg_we   = 1'b0;
    logic [pcc_pkg::CfgIdxW-1:0] i_cfg_idx  = '0;
    logic [pcc_pkg::CfgW-1:0]    i_cfg_data = '0;

    int  chk_errors;
    int  chk_pending;

    // stimulus-side view of the limits that shape error values
    logic [15:0] cur_errlim = pcc_pkg::ERRLIM_RESET;
    logic [15:0] cur_septh  = '0;

    int  tx_burst = 0;
    int  rx_burst = 0;
    bit  tx_flood = 1'b0;
    bit  hold_req = 1'b0;

    always #(ClkPeriod / 2) i_clk = ~i_clk;

    pid_controller_clamped_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    pid_drive_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in        (i_in),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (chk_errors),
        .o_pending   (chk_pending)
    );

    // occasional runs of back-to-back items between random gaps
    function automatic int next_gap(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) begin
            burst_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh7FFF;
            1:       return 16'sh8000;
            2, 3:    return 16'($urandom_range(0, 1200)) - 16'sd600;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_level(input logic [15:0] max_val);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return max_val;
            2, 3:    return 16'($urandom_range(0, (max_val < 2000) ? max_val : 2000));
            default: return 16'($urandom_range(0, max_val));
        endcase
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 16'hFFFF;
            5:       return 16'($urandom);
            default: return 16'($urandom_range(0, 16'h0400));
        endcase
    endfunction

    // an error just around a threshold, either sign
    function automatic int near_bound(input logic [15:0] bound);
        int n;
        n = int'(bound) + int'($urandom_range(0, 2)) - 1;
        return $urandom_range(0, 1) ? -n : n;
    endfunction

    task automatic send_item(input logic signed [15:0] tgt, input logic signed [15:0] meas);
        int gap;
        gap = tx_flood ? 0 : next_gap(tx_burst);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= '{target: tgt, measured: meas};
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_random();
        logic signed [15:0] tgt;
        logic signed [15:0] meas;
        tgt  = pick_sample();
        meas = pick_sample();
        case ($urandom_range(0, 5))
            0:       meas = 16'(int'(tgt) - near_bound(cur_septh));
            1:       meas = 16'(int'(tgt) - near_bound(cur_errlim));
            default: ;
        endcase
        send_item(tgt, meas);
    endtask

    // the pending count is registered, so it lags behind the last accepted item
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [pcc_pkg::CfgIdxW-1:0] idx, input logic [15:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // unused upper bits get random junk
    task automatic load_config(input logic [2:0] mode, input logic [15:0] errlim,
                               input logic [15:0] septh, input logic [14:0] intlim,
                               input logic [14:0] outlim, input logic [15:0] kp,
                               input logic [15:0] ki, input logic [15:0] kd);
        cur_errlim = errlim;
        cur_septh  = septh;
        write_reg(pcc_pkg::REG_MODE,   {13'($urandom), mode});
        write_reg(pcc_pkg::REG_ERRLIM, errlim);
        write_reg(pcc_pkg::REG_SEPTH,  septh);
        write_reg(pcc_pkg::REG_INTLIM, {1'($urandom), intlim});
        write_reg(pcc_pkg::REG_OUTLIM, {1'($urandom), outlim});
        write_reg(pcc_pkg::REG_KP,     kp);
        write_reg(pcc_pkg::REG_KI,     ki);
        write_reg(pcc_pkg::REG_KD,     kd);
        i_cfg_we <= 1'b0;
    endtask

    // result side: random stalls, one long hold-off on request
    initial begin
        int gap;
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                gap = HoldCycles;
            end else begin
                gap = next_gap(rx_burst);
            end
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QuietLimit) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int j;
        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // register defaults: all gains zero
        send_item(16'sh7FFF, 16'sh8000);
        send_item(16'sh8000, 16'sh7FFF);
        send_item(16'sd123, -16'sd45);
        wait_drained();

        // all modes on, error at the separation and clamp bounds
        load_config(3'b111, 16'd1000, 16'd300, 15'd2000, 15'd3000,
                    16'h0180, 16'h0040, 16'h0200);
        send_item(16'sh7FFF, 16'sh8000);
        send_item(16'sh8000, 16'sh7FFF);
        send_item(16'sd0, 16'sd0);
        send_item(16'sh8000, 16'sh8000);
        send_item(16'sh7FFF, 16'sh7FFF);
        send_item(16'sd300, 16'sd0);
        send_item(16'sd0, 16'sd301);
        send_item(16'sd1000, 16'sd0);
        send_item(16'sd1001, 16'sd0);
        send_item(-16'sd1001, 16'sd0);
        wait_drained();

        // no clamps, full-scale gains
        load_config(3'b000, 16'hFFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF,
                    16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(16'sh7FFF, 16'sh8000);
        send_item(16'sh8000, 16'sh7FFF);
        send_item(16'sd1, 16'sd0);
        send_item(16'sd0, 16'sd1);
        wait_drained();

        // zero error, integrator and output limits
        load_config(3'b111, 16'd0, 16'd0, 15'd0, 15'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(16'sd100, -16'sd100);
        send_item(-16'sd5, 16'sd5);
        wait_drained();
        load_config(3'b000, 16'hFFFF, 16'd0, 15'd0, 15'd0, 16'h0100, 16'h0100, 16'h0100);
        send_item(16'sh7FFF, 16'sh8000);
        send_item(-16'sd7, 16'sd3);
        wait_drained();

        // integrator windup into both saturation rails
        load_config(3'b000, 16'hFFFF, 16'd0, 15'h7FFF, 15'h7FFF, 16'd0, 16'hFFFF, 16'd0);
        for (j = 0; j < 150; j++) begin
            send_item(16'sh7FFF - 16'($urandom_range(0, 15)),
                      16'sh8000 + 16'($urandom_range(0, 15)));
        end
        for (j = 0; j < 300; j++) begin
            send_item(16'sh8000 + 16'($urandom_range(0, 15)),
                      16'sh7FFF - 16'($urandom_range(0, 15)));
        end
        wait_drained();

        for (int ph = 0; ph < RandPhases; ph++) begin
            load_config(3'($urandom), pick_level(16'hFFFF), pick_level(16'hFFFF),
                        15'(pick_level(16'h7FFF)), 15'(pick_level(16'h7FFF)),
                        pick_gain(), pick_gain(), pick_gain());
            if (ph == HoldPhase) begin
                hold_req = 1'b1;
                tx_flood = 1'b1;
            end
            for (j = 0; j < PhaseItems; j++) begin
                if (j == 60) tx_flood = 1'b0;
                send_random();
            end
            wait_drained();
        end

        repeat (20) @(posedge i_clk);
        if (chk_errors == 0 && chk_pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
